// File: hdl/adfe_pkg.sv
package adfe_pkg;

    // Widths of the fixed result fields.
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 5;

    // Structure types of interest inside the advertising payload.
    localparam logic [BYTE_W-1:0] TYPE_NAME_SHORT = 8'h08;
    localparam logic [BYTE_W-1:0] TYPE_NAME_FULL  = 8'h09;
    localparam logic [BYTE_W-1:0] TYPE_MFG        = 8'hFF;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_NAME = 2'd0,
        KIND_MFG  = 2'd1,
        KIND_SUM  = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store an accepted input byte
        logic walk_init;  // rewind the walk and clear the field records
        logic rd_len;     // read the length byte at the walk position
        logic len_step;   // take the length, read the type byte
        logic type_step;  // evaluate the type, skip over the structure
        logic emit_init;  // choose the first field to emit
        logic emit_req;   // read the store for the current result item
        logic emit_next;  // the current result item was taken
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_more;  // at least two bytes remain in the walk
        logic len_bad;    // zero length or structure overruns the payload
        logic emit_last;  // the current result item is the summary
    } status_t;

endpackage

// File: hdl/adfe_ram.sv
module adfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/adfe_ctrl.sv
module adfe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              final_byte,
    input  logic              out_ready,
    input  adfe_pkg::status_t status,
    output logic              in_ready,
    output logic              out_valid,
    output adfe_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_RLEN  = 6'b000010,
        S_WLEN  = 6'b000100,
        S_WTYPE = 6'b001000,
        S_EREQ  = 6'b010000,
        S_EOUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (final_byte)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_RLEN;
                    end
                end
            end
            S_RLEN:
            begin
                if (status.walk_more)
                begin
                    cmd.rd_len = 1'b1;
                    state_next = S_WLEN;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EREQ;
                end
            end
            S_WLEN:
            begin
                if (status.len_bad)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_EREQ;
                end
                else
                begin
                    cmd.len_step = 1'b1;
                    state_next   = S_WTYPE;
                end
            end
            S_WTYPE:
            begin
                cmd.type_step = 1'b1;
                state_next    = S_RLEN;
            end
            S_EREQ:
            begin
                cmd.emit_req = 1'b1;
                state_next   = S_EOUT;
            end
            S_EOUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_next = 1'b1;
                    state_next    = status.emit_last ? S_LOAD : S_EREQ;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/adfe_dpath.sv
module adfe_dpath #(
    parameter int MAX_PAYLOAD = 31,
    parameter int MAX_NAME    = 31
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  adfe_pkg::cmd_t                     cmd,
    input  logic [adfe_pkg::BYTE_W-1:0]        ad_byte,
    output adfe_pkg::status_t                  status,
    output logic [1:0]                         kind,
    output logic [adfe_pkg::BYTE_W-1:0]        value,
    output logic [adfe_pkg::FIELD_W-1:0]       position,
    output logic [adfe_pkg::FIELD_W-1:0]       name_length,
    output logic [adfe_pkg::FIELD_W-1:0]       mfg_length,
    output logic                               overflowed,
    output logic                               run_end
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(MAX_PAYLOAD);

    logic [CW-1:0]   cnt_reg;
    logic            ovf_reg;
    logic [CW-1:0]   pos_reg;
    logic [CW-1:0]   len_reg;
    logic [CW-1:0]   name_off_reg;
    logic [CW-1:0]   name_cnt_reg;
    logic [CW-1:0]   mfg_off_reg;
    logic [CW-1:0]   mfg_cnt_reg;
    logic [CW-1:0]   idx_reg;
    adfe_pkg::kind_t kind_reg;

    logic                        full;
    logic [CW-1:0]               pos_inc;
    logic [CW-1:0]               remain;
    logic [CW-1:0]               dlen;
    logic [CW-1:0]               name_clamp;
    logic [CW-1:0]               idx_inc;
    logic [CW-1:0]               base;
    logic                        is_name;
    logic                        wr_en;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [adfe_pkg::BYTE_W-1:0] rd_data;

    // Payload store.
    adfe_ram #(
        .WIDTH (adfe_pkg::BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (ad_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Walk arithmetic. The walk position never passes the loaded count.
    assign full       = (cnt_reg == CW'(MAX_PAYLOAD));
    assign wr_en      = cmd.load && !full;
    assign pos_inc    = pos_reg + 1'b1;
    assign remain     = cnt_reg - pos_inc;
    assign dlen       = len_reg - 1'b1;
    assign name_clamp = (32'(dlen) > MAX_NAME) ? CW'(MAX_NAME) : dlen;
    assign is_name    = ((rd_data == adfe_pkg::TYPE_NAME_FULL)
                        || (rd_data == adfe_pkg::TYPE_NAME_SHORT)) && (dlen != '0);
    assign idx_inc    = idx_reg + 1'b1;
    assign base       = (kind_reg == adfe_pkg::KIND_MFG) ? mfg_off_reg : name_off_reg;

    // Store read port: length, type or emitted byte.
    assign rd_en = cmd.rd_len || cmd.len_step || cmd.emit_req;
    always_comb
    begin
        if (cmd.emit_req)
        begin
            rd_addr = AW'(base + idx_reg);
        end
        else if (cmd.len_step)
        begin
            rd_addr = AW'(pos_inc);
        end
        else
        begin
            rd_addr = AW'(pos_reg);
        end
    end

    // Status for the controller. The position is checked against the count as well,
    // so a wrapped remaining count is ignored when the walk ends exactly at the loaded count.
    assign status.walk_more = (pos_reg < cnt_reg) && (remain != '0);
    assign status.len_bad   = (rd_data == '0) || (8'(remain) < rd_data);
    assign status.emit_last = (kind_reg == adfe_pkg::KIND_SUM);

    // Load, walk and emission registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
            name_off_reg <= '0;
            name_cnt_reg <= '0;
            mfg_off_reg  <= '0;
            mfg_cnt_reg  <= '0;
            idx_reg      <= '0;
            kind_reg     <= adfe_pkg::KIND_SUM;
        end
        else
        begin
            if (cmd.load)
            begin
                if (full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.walk_init)
            begin
                pos_reg      <= '0;
                name_off_reg <= '0;
                name_cnt_reg <= '0;
                mfg_off_reg  <= '0;
                mfg_cnt_reg  <= '0;
            end
            if (cmd.len_step)
            begin
                pos_reg <= pos_inc;
                len_reg <= CW'(rd_data);
            end
            if (cmd.type_step)
            begin
                if (is_name)
                begin
                    name_off_reg <= pos_inc;
                    name_cnt_reg <= name_clamp;
                end
                else if (rd_data == adfe_pkg::TYPE_MFG)
                begin
                    mfg_off_reg <= pos_inc;
                    mfg_cnt_reg <= dlen;
                end
                pos_reg <= pos_reg + len_reg;
            end
            if (cmd.emit_init)
            begin
                idx_reg <= '0;
                if (name_cnt_reg != '0)
                begin
                    kind_reg <= adfe_pkg::KIND_NAME;
                end
                else if (mfg_cnt_reg != '0)
                begin
                    kind_reg <= adfe_pkg::KIND_MFG;
                end
                else
                begin
                    kind_reg <= adfe_pkg::KIND_SUM;
                end
            end
            if (cmd.emit_next)
            begin
                case (kind_reg)
                    adfe_pkg::KIND_NAME:
                    begin
                        if (idx_inc < name_cnt_reg)
                        begin
                            idx_reg <= idx_inc;
                        end
                        else
                        begin
                            idx_reg  <= '0;
                            kind_reg <= (mfg_cnt_reg != '0) ? adfe_pkg::KIND_MFG
                                                            : adfe_pkg::KIND_SUM;
                        end
                    end
                    adfe_pkg::KIND_MFG:
                    begin
                        if (idx_inc < mfg_cnt_reg)
                        begin
                            idx_reg <= idx_inc;
                        end
                        else
                        begin
                            idx_reg  <= '0;
                            kind_reg <= adfe_pkg::KIND_SUM;
                        end
                    end
                    default:
                    begin
                        // Summary taken: ready for the next payload.
                        cnt_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Result fields.
    assign kind        = kind_reg;
    assign value       = (kind_reg == adfe_pkg::KIND_SUM) ? '0 : rd_data;
    assign position    = adfe_pkg::FIELD_W'(idx_reg);
    assign name_length = adfe_pkg::FIELD_W'(name_cnt_reg);
    assign mfg_length  = adfe_pkg::FIELD_W'(mfg_cnt_reg);
    assign overflowed  = ovf_reg;
    assign run_end     = (kind_reg == adfe_pkg::KIND_SUM);

endmodule

// File: hdl/adv_data_field_extractor.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   ad_byte, final_byte
// output   out_valid / out_ready kind, value, position, name_length, mfg_length,
//                                overflowed, run_end
//
// A byte is taken whenever in_valid is high in S_LOAD; input is held off from the final byte until the
// summary item has been taken.
// The walk reads the store through its single registered port: each length-type-value structure passes
// S_RLEN, S_WLEN and S_WTYPE; the walk ends in S_RLEN, or in S_WLEN when a bad length ends it.
// Each result item is a store read in S_EREQ, then a hold on the output in S_EOUT until
// out_ready is high; a stalled output simply holds the item.
// Reset clears all control state; the payload store needs no clearing.
module adv_data_field_extractor #(
    parameter int MAX_PAYLOAD = 31,
    parameter int MAX_NAME    = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [adfe_pkg::BYTE_W-1:0]  ad_byte,
    input  logic                         final_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [adfe_pkg::BYTE_W-1:0]  value,
    output logic [adfe_pkg::FIELD_W-1:0] position,
    output logic [adfe_pkg::FIELD_W-1:0] name_length,
    output logic [adfe_pkg::FIELD_W-1:0] mfg_length,
    output logic                         overflowed,
    output logic                         run_end
);

    adfe_pkg::cmd_t    cmd;
    adfe_pkg::status_t status;

    // Controller.
    adfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_byte (final_byte),
        .out_ready  (out_ready),
        .status     (status),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    // Datapath with the payload store.
    adfe_dpath #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_NAME    (MAX_NAME)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .ad_byte     (ad_byte),
        .status      (status),
        .kind        (kind),
        .value       (value),
        .position    (position),
        .name_length (name_length),
        .mfg_length  (mfg_length),
        .overflowed  (overflowed),
        .run_end     (run_end)
    );

    // Input and output never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted while a result item is pending");

    // A name byte lies inside the kept name.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == adfe_pkg::KIND_NAME) |-> (position < name_length))
        else $error("name byte position beyond name length");

    // A manufacturer byte lies inside the kept manufacturer data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == adfe_pkg::KIND_MFG) |-> (position < mfg_length))
        else $error("manufacturer byte position beyond data length");

    // After the summary is taken the block waits for a new payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && run_end) |=> (in_ready && !out_valid))
        else $error("block did not return to loading after the summary");

endmodule

// File: dv/tb_adv_data_field_extractor.sv
module tb_adv_data_field_extractor;

    localparam int MAX_PAYLOAD = 31;
    localparam int MAX_NAME    = 31;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 80;
    localparam int DRAIN_WAIT  = 20;

    // One result item as seen on the output ports.
    typedef struct {
        logic [1:0]                   kind;
        logic [adfe_pkg::BYTE_W-1:0]  value;
        logic [adfe_pkg::FIELD_W-1:0] position;
        logic [adfe_pkg::FIELD_W-1:0] name_length;
        logic [adfe_pkg::FIELD_W-1:0] mfg_length;
        logic                         overflowed;
        logic                         run_end;
    } ad_result_t;

    // Mirrors the payload store and predicts the fields extracted from each payload.
    class field_scoreboard;
        logic [adfe_pkg::BYTE_W-1:0] payload [MAX_PAYLOAD];
        int                          loaded;
        bit                          dropped;
        ad_result_t                  expected_q [$];
        int                          errors;

        function ad_result_t pack_result(adfe_pkg::kind_t k, logic [adfe_pkg::BYTE_W-1:0] v,
                                         int p, int name_cnt, int mfg_cnt);
            ad_result_t r;
            r.kind        = k;
            r.value       = v;
            r.position    = adfe_pkg::FIELD_W'(p);
            r.name_length = adfe_pkg::FIELD_W'(name_cnt);
            r.mfg_length  = adfe_pkg::FIELD_W'(mfg_cnt);
            r.overflowed  = dropped;
            r.run_end     = (k == adfe_pkg::KIND_SUM);
            return r;
        endfunction

        // Store an accepted item; on the final byte walk the structures and queue
        // the name bytes, the manufacturer bytes and the summary.
        function void note_byte(logic [adfe_pkg::BYTE_W-1:0] b, logic fin);
            int                          pos;
            int                          n;
            int                          len;
            int                          dlen;
            int                          name_off;
            int                          name_cnt;
            int                          mfg_off;
            int                          mfg_cnt;
            logic [adfe_pkg::BYTE_W-1:0] typ;

            if (loaded < MAX_PAYLOAD)
            begin
                payload[loaded] = b;
                loaded++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!fin)
            begin
                return;
            end

            pos      = 0;
            n        = loaded;
            name_off = 0;
            name_cnt = 0;
            mfg_off  = 0;
            mfg_cnt  = 0;
            while (pos < n && n - pos > 1)
            begin
                len = int'(payload[pos]);
                pos++;
                // A zero length or a structure running past the payload ends the walk.
                if (len == 0 || n - pos < len)
                begin
                    break;
                end
                typ  = payload[pos];
                pos++;
                dlen = len - 1;
                if ((typ == adfe_pkg::TYPE_NAME_FULL || typ == adfe_pkg::TYPE_NAME_SHORT)
                    && dlen > 0)
                begin
                    name_off = pos;
                    name_cnt = (dlen < MAX_NAME) ? dlen : MAX_NAME;
                end
                else if (typ == adfe_pkg::TYPE_MFG)
                begin
                    mfg_off = pos;
                    mfg_cnt = dlen;
                end
                pos += dlen;
            end

            for (int i = 0; i < name_cnt; i++)
            begin
                expected_q.push_back(pack_result(adfe_pkg::KIND_NAME, payload[name_off + i],
                                                 i, name_cnt, mfg_cnt));
            end
            for (int i = 0; i < mfg_cnt; i++)
            begin
                expected_q.push_back(pack_result(adfe_pkg::KIND_MFG, payload[mfg_off + i],
                                                 i, name_cnt, mfg_cnt));
            end
            expected_q.push_back(pack_result(adfe_pkg::KIND_SUM, '0, 0, name_cnt, mfg_cnt));

            loaded  = 0;
            dropped = 1'b0;
        endfunction

        function void compare(string field, logic [adfe_pkg::BYTE_W-1:0] want,
                              logic [adfe_pkg::BYTE_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result item with the oldest expectation.
        function void check_result(ad_result_t got);
            ad_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing expected: kind %0h value %0h",
                       got.kind, got.value);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare("kind", adfe_pkg::BYTE_W'(want.kind), adfe_pkg::BYTE_W'(got.kind));
            compare("value", want.value, got.value);
            compare("position", adfe_pkg::BYTE_W'(want.position),
                    adfe_pkg::BYTE_W'(got.position));
            compare("name_length", adfe_pkg::BYTE_W'(want.name_length),
                    adfe_pkg::BYTE_W'(got.name_length));
            compare("mfg_length", adfe_pkg::BYTE_W'(want.mfg_length),
                    adfe_pkg::BYTE_W'(got.mfg_length));
            compare("overflowed", adfe_pkg::BYTE_W'(want.overflowed),
                    adfe_pkg::BYTE_W'(got.overflowed));
            compare("run_end", adfe_pkg::BYTE_W'(want.run_end),
                    adfe_pkg::BYTE_W'(got.run_end));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [adfe_pkg::BYTE_W-1:0]  ad_byte;
    logic                         final_byte;
    logic                         out_valid;
    logic                         out_ready;
    logic [1:0]                   kind;
    logic [adfe_pkg::BYTE_W-1:0]  value;
    logic [adfe_pkg::FIELD_W-1:0] position;
    logic [adfe_pkg::FIELD_W-1:0] name_length;
    logic [adfe_pkg::FIELD_W-1:0] mfg_length;
    logic                         overflowed;
    logic                         run_end;

    field_scoreboard              sb;
    logic [adfe_pkg::BYTE_W-1:0]  pl [$];
    bit                           calm;
    bit                           hold_req;

    adv_data_field_extractor #(
        .MAX_PAYLOAD(MAX_PAYLOAD),
        .MAX_NAME   (MAX_NAME)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ad_byte    (ad_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .value      (value),
        .position   (position),
        .name_length(name_length),
        .mfg_length (mfg_length),
        .overflowed (overflowed),
        .run_end    (run_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and wait until it is accepted.
    task automatic send_byte(input logic [adfe_pkg::BYTE_W-1:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        ad_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b, fin);
    endtask

    task automatic send_payload();
        for (int i = 0; i < pl.size(); i++)
        begin
            send_byte(pl[i], (i == pl.size() - 1));
        end
    endtask

    // Withdraw the last accepted item, then wait for every expected result.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Append well-formed structures with random types and contents up to target bytes.
    task automatic add_fields(input int target);
        int                          room;
        int                          dlen;
        logic [adfe_pkg::BYTE_W-1:0] typ;
        while (target - pl.size() >= 2)
        begin
            room = target - pl.size() - 2;
            dlen = $urandom_range(0, (room > 10) ? 10 : room);
            case ($urandom_range(0, 3))
                0:       typ = adfe_pkg::TYPE_NAME_FULL;
                1:       typ = adfe_pkg::TYPE_NAME_SHORT;
                2:       typ = adfe_pkg::TYPE_MFG;
                default: typ = adfe_pkg::BYTE_W'($urandom_range(0, 255));
            endcase
            pl.push_back(adfe_pkg::BYTE_W'(dlen + 1));
            pl.push_back(typ);
            repeat (dlen) pl.push_back(adfe_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_payload();
        int mode;
        int extra;
        pl.delete();
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            add_fields(($urandom_range(0, 5) == 0) ? MAX_PAYLOAD : $urandom_range(2, 14));
        end
        else if (mode < 8)
        begin
            // Good structures, then a zero length, an overrun or a lone trailing byte.
            add_fields($urandom_range(0, 8));
            case ($urandom_range(0, 2))
                0:
                begin
                    pl.push_back(8'h00);
                    pl.push_back(adfe_pkg::BYTE_W'($urandom_range(0, 255)));
                end
                1:
                begin
                    pl.push_back(adfe_pkg::BYTE_W'($urandom_range(3, 255)));
                    pl.push_back(adfe_pkg::TYPE_MFG);
                end
                default: pl.push_back(adfe_pkg::BYTE_W'($urandom_range(1, 255)));
            endcase
        end
        else if (mode == 8)
        begin
            // Fill the store and run past it so that bytes are dropped.
            add_fields(MAX_PAYLOAD);
            extra = $urandom_range(1, 5) + MAX_PAYLOAD - pl.size();
            repeat (extra) pl.push_back(adfe_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                pl.push_back(adfe_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (calm || stall_left == 0)
            begin
                out_ready <= 1'b1;
                if (!calm)
                begin
                    stall_left = pick_gap();
                end
            end
            else
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
        end
    end

    // Check every result item taken at a rising edge.
    initial
    begin
        ad_result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
            begin
                got.kind        = kind;
                got.value       = value;
                got.position    = position;
                got.name_length = name_length;
                got.mfg_length  = mfg_length;
                got.overflowed  = overflowed;
                got.run_end     = run_end;
                sb.check_result(got);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, directed payloads, then random payloads.
    initial
    begin
        int rand_items;
        int npl;
        sb         = new;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        ad_byte    = '0;
        final_byte = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single byte: nothing to walk, summary only.
        pl = {8'h00};
        send_payload();
        // Complete name and manufacturer data with extreme byte values.
        pl = {8'h02, adfe_pkg::TYPE_NAME_FULL, 8'hFF, 8'h02, adfe_pkg::TYPE_MFG, 8'h00};
        send_payload();
        // Shortened name, an empty name that is ignored, another type skipped,
        // and a lone trailing byte.
        pl = {8'h02, adfe_pkg::TYPE_NAME_SHORT, 8'h41, 8'h01, adfe_pkg::TYPE_NAME_FULL,
              8'h01, 8'h06, 8'h80};
        send_payload();
        // Empty manufacturer data clears the earlier one; then a structure overruns.
        pl = {8'h03, adfe_pkg::TYPE_MFG, 8'h11, 8'h22, 8'h01, adfe_pkg::TYPE_MFG,
              8'h05, adfe_pkg::TYPE_NAME_FULL};
        send_payload();
        // A zero length stops the walk.
        pl = {8'h02, adfe_pkg::TYPE_NAME_FULL, 8'h7E, 8'h00, 8'h05};
        send_payload();
        wait_drained();

        rand_items = 0;
        npl        = 0;
        while (rand_items < RAND_ITEMS)
        begin
            calm = (npl >= 6 && npl < 9);
            if (npl == 2)
            begin
                hold_req = 1'b1;
            end
            if (npl == 5 || npl == 12)
            begin
                wait_drained();
            end
            build_payload();
            send_payload();
            rand_items += pl.size();
            npl++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
